// ----- rtl/core/modular_exponentiation_assert.svh -----
// Assertion macros shared by the modular exponentiation RTL
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define MEXP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included
`define MEXP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/mexp_pkg.sv -----
package mexp_pkg;

	// Port field width and default operand width
	localparam int FIELD_W   = 32;
	localparam int WIDTH_DEF = 32;

	// Datapath operation codes
	localparam int OP_W = 3;
	typedef logic [OP_W-1:0] dp_op_t;

	localparam dp_op_t DP_HOLD    = 3'd0;
	localparam dp_op_t DP_LOAD    = 3'd1;
	localparam dp_op_t DP_STEP    = 3'd2;
	localparam dp_op_t DP_SET_B   = 3'd3;
	localparam dp_op_t DP_SET_MUL = 3'd4;
	localparam dp_op_t DP_SET_SQR = 3'd5;
	localparam dp_op_t DP_SAVE_R  = 3'd6;
	localparam dp_op_t DP_SAVE_B  = 3'd7;

	// Controller to datapath
	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} mexp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic m_zero;
		logic e_zero;
		logic e_lsb;
		logic e_last;
	} mexp_sts_t;

endpackage

// ----- rtl/core/mexp_if.sv -----
// Input channel: base, exponent and modulus
interface mexp_in_if;
	import mexp_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] base_value;
	logic [FIELD_W-1:0] exponent;
	logic [FIELD_W-1:0] modulus;

	modport source (output valid, output base_value, output exponent, output modulus,
		input ready);
	modport sink (input valid, input base_value, input exponent, input modulus,
		output ready);
endinterface

// Output channel: modular power and error flag
interface mexp_out_if;
	import mexp_pkg::*;

	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] power_result;
	logic               bad_modulus;

	modport source (output valid, output power_result, output bad_modulus, input ready);
	modport sink (input valid, input power_result, input bad_modulus, output ready);
endinterface

// ----- rtl/core/modular_exponentiation.sv -----
// Modular exponentiation, right-to-left binary square-and-multiply, one item at a time.
// The product and square steps use one shared shift-and-add modular multiplier, one bit per
// cycle. A new request is taken only after the previous result is loaded for output. Reset
// (arst_n, asynchronous, active low) idles the controller and drops the output valid.
module modular_exponentiation #(
	parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mexp_in_if.sink     in_ch,
	mexp_out_if.source  out_ch
);
	import mexp_pkg::*;

	mexp_cmd_t cmd;
	mexp_sts_t sts;

	// Sequence control
	mexp_ctrl #(
		.WIDTH(WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Operands, modular multiplier and result register
	mexp_dp #(
		.WIDTH(WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.base_value  (in_ch.base_value),
		.exponent    (in_ch.exponent),
		.modulus     (in_ch.modulus),
		.power_result(out_ch.power_result),
		.bad_modulus (out_ch.bad_modulus)
	);

endmodule

// ----- rtl/core/mexp_dp.sv -----
`include "modular_exponentiation_assert.svh"

module mexp_dp #(
	parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mexp_pkg::mexp_cmd_t         cmd,
	output mexp_pkg::mexp_sts_t         sts,
	input  logic [mexp_pkg::FIELD_W-1:0] base_value,
	input  logic [mexp_pkg::FIELD_W-1:0] exponent,
	input  logic [mexp_pkg::FIELD_W-1:0] modulus,
	output logic [mexp_pkg::FIELD_W-1:0] power_result,
	output logic                        bad_modulus
);
	import mexp_pkg::*;

	localparam int OW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;

	logic [OW-1:0]    m_q, e_q, b_q, r_q;
	logic [OW-1:0]    acc_q, a_q, x_q;
	logic [FIELD_W-1:0] res_q;
	logic             bad_q;

	logic [OW+2:0]    sum_w, d1_w, d2_w;
	logic [OW-1:0]    step_w;

	// One shift-and-add step: (2*acc + bit*a) mod m, sum stays below 3m
	always_comb begin
		sum_w  = {2'b00, acc_q, 1'b0} + {3'b000, (x_q[OW-1] ? a_q : {OW{1'b0}})};
		d1_w   = sum_w - {3'b000, m_q};
		d2_w   = sum_w - {2'b00, m_q, 1'b0};
		if (!d2_w[OW+2]) begin
			step_w = d2_w[OW-1:0];
		end else if (!d1_w[OW+2]) begin
			step_w = d1_w[OW-1:0];
		end else begin
			step_w = sum_w[OW-1:0];
		end
	end

	// Operand and working registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LOAD: begin
				m_q   <= modulus[OW-1:0];
				e_q   <= exponent[OW-1:0];
				r_q   <= OW'(1);
				acc_q <= '0;
				a_q   <= OW'(1);
				x_q   <= base_value[OW-1:0];
			end
			DP_STEP: begin
				acc_q <= step_w;
				x_q   <= {x_q[OW-2:0], 1'b0};
			end
			DP_SET_B: begin
				b_q <= acc_q;
			end
			DP_SET_MUL: begin
				acc_q <= '0;
				a_q   <= r_q;
				x_q   <= b_q;
			end
			DP_SET_SQR: begin
				acc_q <= '0;
				a_q   <= b_q;
				x_q   <= b_q;
			end
			DP_SAVE_R: begin
				// save product and prime the square of the base power
				r_q   <= acc_q;
				acc_q <= '0;
				a_q   <= b_q;
				x_q   <= b_q;
			end
			DP_SAVE_B: begin
				b_q <= acc_q;
				e_q <= {1'b0, e_q[OW-1:1]};
			end
			default: begin
			end
		endcase
	end

	// Output holding register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_q <= (m_q == '0) ? '0 : FIELD_W'(r_q);
			bad_q <= (m_q == '0);
		end
	end

	assign sts.m_zero   = (m_q == '0);
	assign sts.e_zero   = (e_q == '0);
	assign sts.e_lsb    = e_q[0];
	assign sts.e_last   = (e_q[OW-1:1] == '0);
	assign power_result = res_q;
	assign bad_modulus  = bad_q;

	`MEXP_ASSERT(a_acc_reduced, (cmd.op == DP_STEP && m_q != '0) |=> (acc_q < m_q), "mexp_dp: step left accumulator unreduced")

endmodule

// ----- rtl/core/mexp_ctrl.sv -----
`include "modular_exponentiation_assert.svh"

module mexp_ctrl #(
	parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  mexp_pkg::mexp_sts_t sts,
	output mexp_pkg::mexp_cmd_t cmd
);
	import mexp_pkg::*;

	localparam int OW = (WIDTH < FIELD_W) ? WIDTH : FIELD_W;
	localparam int CW = $clog2(OW);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RED    = 4'd1;
	localparam logic [3:0] S_SETB   = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_MUL    = 4'd4;
	localparam logic [3:0] S_SAVER  = 4'd5;
	localparam logic [3:0] S_SQR    = 4'd6;
	localparam logic [3:0] S_SAVEB  = 4'd7;
	localparam logic [3:0] S_WRITE  = 4'd8;

	logic [3:0]    state_q, state_d;
	logic [CW-1:0] cnt_q;
	logic          cnt_inc;
	logic          cnt_last;
	logic          out_valid_q;
	logic          slot_free;

	assign cnt_last  = (cnt_q == CW'(OW - 1));
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and datapath command
	always_comb begin
		state_d      = state_q;
		cmd.op       = DP_HOLD;
		cmd.out_load = 1'b0;
		cnt_inc      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = DP_LOAD;
					state_d = S_RED;
				end
			end
			S_RED: begin
				if (sts.m_zero) begin
					state_d = S_WRITE;
				end else begin
					cmd.op  = DP_STEP;
					cnt_inc = 1'b1;
					if (cnt_last) begin
						state_d = S_SETB;
					end
				end
			end
			S_SETB: begin
				cmd.op  = DP_SET_B;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.e_zero) begin
					state_d = S_WRITE;
				end else if (sts.e_lsb) begin
					cmd.op  = DP_SET_MUL;
					state_d = S_MUL;
				end else begin
					cmd.op  = DP_SET_SQR;
					state_d = S_SQR;
				end
			end
			S_MUL: begin
				cmd.op  = DP_STEP;
				cnt_inc = 1'b1;
				if (cnt_last) begin
					state_d = S_SAVER;
				end
			end
			S_SAVER: begin
				cmd.op  = DP_SAVE_R;
				state_d = sts.e_last ? S_WRITE : S_SQR;
			end
			S_SQR: begin
				cmd.op  = DP_STEP;
				cnt_inc = 1'b1;
				if (cnt_last) begin
					state_d = S_SAVEB;
				end
			end
			S_SAVEB: begin
				cmd.op  = DP_SAVE_B;
				state_d = S_DECIDE;
			end
			S_WRITE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, bit counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc && !cnt_last) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`MEXP_ASSERT(a_accept_reduce, (in_valid && in_ready) |=> (state_q == S_RED), "mexp_ctrl: transfer did not start reduction")
	`MEXP_ASSERT(a_load_slot, cmd.out_load |-> slot_free, "mexp_ctrl: result overwrote a pending transfer")
	`MEXP_ASSERT(a_zero_mod, (state_q == S_RED && sts.m_zero) |=> (state_q == S_WRITE), "mexp_ctrl: zero modulus not sent to output")
	`MEXP_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CW'(OW - 1), "mexp_ctrl: bit counter out of range")

endmodule

// ----- tb/mexp_checker.sv -----
// Watches both channels of the exponentiation block, predicts each power and
// compares it against the result transfers in order.
module mexp_checker #(
	parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mexp_in_if   in_ch,
	mexp_out_if  out_ch,
	output int   errors,
	output int   pending,
	output int   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import mexp_pkg::*;

	typedef struct packed {
		logic [FIELD_W-1:0] power;
		logic               bad;
	} power_t;

	power_t expected_powers[$];
	int     fail_count;
	int     check_count;

	// Square-and-multiply from the low exponent bit upward, exact at double width
	function automatic power_t predict_power(input logic [FIELD_W-1:0] b_in,
		input logic [FIELD_W-1:0] e_in, input logic [FIELD_W-1:0] m_in);
		logic [FIELD_W-1:0] msk;
		logic [63:0]        acc;
		logic [63:0]        sq;
		logic [63:0]        mm;
		logic [FIELD_W-1:0] ex;
		power_t             res;
		msk = (WIDTH >= FIELD_W) ? '1 : ((FIELD_W'(1) << WIDTH) - 1'b1);
		mm  = 64'(m_in & msk);
		ex  = e_in & msk;
		if (mm == 0) begin
			res.power = '0;
			res.bad   = 1'b1;
			return res;
		end
		sq  = 64'(b_in & msk) % mm;
		acc = 64'd1;
		while (ex != 0) begin
			if (ex[0])
				acc = (acc * sq) % mm;
			sq = (sq * sq) % mm;
			ex = ex >> 1;
		end
		res.power = acc[FIELD_W-1:0];
		res.bad   = 1'b0;
		return res;
	endfunction

	initial begin
		fail_count  = 0;
		check_count = 0;
	end

	// Check result transfers first, then queue the prediction for a new request
	always @(posedge clk) begin
		power_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				check_count++;
				if (expected_powers.size() == 0) begin
					$display("%0t: result with nothing outstanding: power=%h bad=%b",
						$time, out_ch.power_result, out_ch.bad_modulus);
					fail_count++;
				end else begin
					want = expected_powers.pop_front();
					if (out_ch.power_result !== want.power) begin
						$display("%0t: power_result mismatch: expected %h, actual %h",
							$time, want.power, out_ch.power_result);
						fail_count++;
					end
					if (out_ch.bad_modulus !== want.bad) begin
						$display("%0t: bad_modulus mismatch: expected %b, actual %b",
							$time, want.bad, out_ch.bad_modulus);
						fail_count++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_powers.push_back(predict_power(in_ch.base_value, in_ch.exponent,
					in_ch.modulus));
			errors  <= fail_count;
			pending <= expected_powers.size();
			checked <= check_count;
		end
	end

endmodule

// ----- tb/tb_modular_exponentiation.sv -----
module tb_modular_exponentiation;
	timeunit 1ns;
	timeprecision 1ps;

	import mexp_pkg::*;

	localparam int RANDOM_ITEMS = 260;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int HOLD_AT      = 40;
	localparam int HOLD_CYCLES  = 6000;
	localparam int DRAIN_CYCLES = 4 * WIDTH_DEF + 20;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   checked;
	int   sent;
	int   zero_mod_sent;
	int   burst_left;
	int   cycles;

	mexp_in_if  in_ch ();
	mexp_out_if out_ch ();

	modular_exponentiation i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	mexp_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.errors  (errors),
		.pending (pending),
		.checked (checked)
	);

	// Generate the 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
		$display("tb: failure");
		$finish;
	end

	// Offer one request and hold it until transfer; end the burst with a random gap
	task automatic send_power_request(input logic [FIELD_W-1:0] b,
		input logic [FIELD_W-1:0] e, input logic [FIELD_W-1:0] m);
		int gap;
		in_ch.valid      <= 1'b1;
		in_ch.base_value <= b;
		in_ch.exponent   <= e;
		in_ch.modulus    <= m;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sent++;
		if (m == 0)
			zero_mod_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 6);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Drop valid and wait for every outstanding result
	task automatic wait_for_drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Mix of extremes, powers of two, small values and full random words
	function automatic logic [FIELD_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
			3: return FIELD_W'($urandom_range(1, 15));
			4, 5: return $urandom >> $urandom_range(1, FIELD_W - 1);
			default: return $urandom;
		endcase
	endfunction

	// Stall results on a changing pattern, with one long hold-off
	initial begin : result_sink
		int taken;
		int hold_left;
		int mode;
		int span;
		bit held;
		taken     = 0;
		hold_left = 0;
		mode      = 0;
		span      = 0;
		held      = 1'b0;
		out_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				taken++;
			if (!held && taken == HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (span == 0) begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(16, 200);
			end
			span--;
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= 1'($urandom_range(0, 1));
					2: out_ch.ready <= ($urandom_range(0, 3) == 0);
					default: out_ch.ready <= ((span % 3) != 0);
				endcase
			end
		end
	end

	// Reset, directed requests, random requests, drain and verdict
	initial begin
		logic [FIELD_W-1:0] m;
		sent          = 0;
		zero_mod_sent = 0;
		burst_left    = 0;
		arst_n           <= 1'b0;
		in_ch.valid      <= 1'b0;
		in_ch.base_value <= '0;
		in_ch.exponent   <= '0;
		in_ch.modulus    <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero modulus, zero exponent, modulus one and operand extremes
		send_power_request(32'd5,        32'd0,        32'd0);
		send_power_request(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
		send_power_request(32'd7,        32'd0,        32'd1);
		send_power_request(32'hFFFFFFFF, 32'd0,        32'hFFFFFFFF);
		send_power_request(32'd0,        32'd0,        32'd2);
		send_power_request(32'd0,        32'd1,        32'd1);
		send_power_request(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1);
		send_power_request(32'd0,        32'd3,        32'd13);
		send_power_request(32'd3,        32'd5,        32'd7);
		send_power_request(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_power_request(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFB);
		send_power_request(32'hFFFFFFFE, 32'd2,        32'hFFFFFFFF);
		send_power_request(32'd2,        32'h80000000, 32'hFFFFFFFB);
		send_power_request(32'h12345678, 32'd1,        32'd1000);
		send_power_request(32'd97,       32'd7,        32'd97);
		send_power_request(32'd1,        32'hFFFFFFFF, 32'h80000000);
		send_power_request(32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFC5);
		send_power_request(32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFE);
		send_power_request(32'd2,        32'd31,       32'h80000000);
		send_power_request(32'hFFFFFFFF, 32'd1,        32'd2);
		send_power_request($urandom,     $urandom,     32'h00000003);
		wait_for_drain();

		// Random requests, with one full pause halfway
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			m = ($urandom_range(0, 15) == 0) ? '0 : pick_word();
			send_power_request(pick_word(), pick_word(), m);
			if (i == RANDOM_ITEMS / 2)
				wait_for_drain();
		end
		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d requests (%0d with zero modulus), %0d results checked",
			sent, zero_mod_sent, checked);
		$display("including operand extremes, stalls and a %0d-cycle result hold-off",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors, pending);
			$display("tb: failure");
		end
		$finish;
	end

endmodule
